// ===== sv/sds_pkg.sv =====
package sds_pkg;

  localparam int THR_W      = 19;
  localparam int SHIFT_W    = 2;
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int DIR_W      = 4;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1024);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_DIST_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT      = 1'b1;

  // event kinds
  localparam logic OP_PRESS  = 1'b0;
  localparam logic OP_MOTION = 1'b1;

  typedef struct packed {
    logic load_anchor;
    logic clear_count;
    logic bump_count;
  } step_ctl_t;

endpackage

// ===== sv/sds_cfg_regs.sv =====
module sds_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic [sds_pkg::THR_W-1:0]              min_step_dist_sq,
  output logic [sds_pkg::SHIFT_W-1:0]            scale_shift
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_dist_sq <= sds_pkg::THR_RESET;
      scale_shift      <= sds_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sds_pkg::REG_MIN_STEP_DIST_SQ: begin
          min_step_dist_sq <= cfg_data[sds_pkg::THR_W-1:0];
        end
        sds_pkg::REG_SCALE_SHIFT: begin
          scale_shift <= cfg_data[sds_pkg::SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/sds_sector.sv =====
module sds_sector #(
  parameter int COORD_BITS = 9
) (
  input  logic signed [COORD_BITS:0]       dx,
  input  logic signed [COORD_BITS:0]       dy,
  output logic        [sds_pkg::DIR_W-1:0] direction
);

  localparam int SW = COORD_BITS + 5;

  logic signed [SW-1:0] ax, ay, fx, fy, fx5, fy5;
  logic                 neg_y, neg_x;
  logic [1:0]           slope_cnt;

  always_comb begin
    ax    = SW'(dx);
    ay    = SW'(dy);
    neg_y = ay < 0;
    if (neg_y) begin
      ax = -ax;
      ay = -ay;
    end
    neg_x = ax < 0;
    // rotate the left half-plane into the first quadrant
    if (neg_x) begin
      fx = ay;
      fy = -ax;
    end else begin
      fx = ax;
      fy = ay;
    end
    fx5 = (fx <<< 2) + fx;
    fy5 = (fy <<< 2) + fy;
    slope_cnt = 2'((fy <<< 1) > fx5) + 2'(fy > fx) + 2'(fy5 > (fx <<< 1));
    direction = {neg_y, neg_x, slope_cnt};
  end

endmodule

// ===== sv/sds_step.sv =====
module sds_step #(
  parameter int COORD_BITS   = 9,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                            op,
  input  logic [COORD_BITS-1:0]           x_pos,
  input  logic [COORD_BITS-1:0]           y_pos,
  input  logic [COORD_BITS-1:0]           anchor_x,
  input  logic [COORD_BITS-1:0]           anchor_y,
  input  logic [COORD_BITS-1:0]           min_x,
  input  logic [COORD_BITS-1:0]           max_x,
  input  logic [COORD_BITS-1:0]           min_y,
  input  logic [COORD_BITS-1:0]           max_y,
  input  logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_count,
  input  logic [sds_pkg::THR_W-1:0]       min_step_dist_sq,
  input  logic [sds_pkg::SHIFT_W-1:0]     scale_shift,
  output sds_pkg::step_ctl_t              ctl,
  output logic [COORD_BITS-1:0]           min_x_next,
  output logic [COORD_BITS-1:0]           max_x_next,
  output logic [COORD_BITS-1:0]           min_y_next,
  output logic [COORD_BITS-1:0]           max_y_next,
  output logic signed [COORD_BITS+3:0]    step_dx,
  output logic signed [COORD_BITS+3:0]    step_dy,
  output logic [sds_pkg::DIR_W-1:0]       direction
);

  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int DW    = (SQ_W > sds_pkg::THR_W) ? SQ_W : sds_pkg::THR_W;

  logic signed [COORD_BITS:0]   dx, dy;
  logic        [COORD_BITS-1:0] adx, ady;
  logic        [DW-1:0]         dist_sq;
  logic                         full, record;
  logic signed [COORD_BITS+3:0] sdx, sdy;
  logic        [sds_pkg::DIR_W-1:0] sector;

  assign full = segment_count == CW'(MAX_SEGMENTS);
  assign dx   = $signed({1'b0, x_pos}) - $signed({1'b0, anchor_x});
  assign dy   = $signed({1'b0, y_pos}) - $signed({1'b0, anchor_y});
  assign adx  = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign dist_sq = DW'(adx * adx) + DW'(ady * ady);

  assign record = (op == sds_pkg::OP_MOTION) && !full && (dist_sq >= DW'(min_step_dist_sq));

  assign sdx = (COORD_BITS + 4)'(dx) <<< scale_shift;
  assign sdy = (COORD_BITS + 4)'(dy) <<< scale_shift;

  // scaling by a power of two leaves the sector unchanged
  sds_sector #(.COORD_BITS(COORD_BITS)) u_sector (
    .dx        (dx),
    .dy        (dy),
    .direction (sector)
  );

  always_comb begin
    min_x_next = min_x;
    max_x_next = max_x;
    min_y_next = min_y;
    max_y_next = max_y;
    if (op == sds_pkg::OP_PRESS) begin
      min_x_next = x_pos;
      max_x_next = x_pos;
      min_y_next = y_pos;
      max_y_next = y_pos;
    end else if (!full) begin
      if (x_pos > max_x) begin
        max_x_next = x_pos;
      end else if (x_pos < min_x) begin
        min_x_next = x_pos;
      end
      if (y_pos > max_y) begin
        max_y_next = y_pos;
      end else if (y_pos < min_y) begin
        min_y_next = y_pos;
      end
    end
  end

  always_comb begin
    ctl.load_anchor = (op == sds_pkg::OP_PRESS) || record;
    ctl.clear_count = op == sds_pkg::OP_PRESS;
    ctl.bump_count  = record;
    step_dx   = record ? sdx : '0;
    step_dy   = record ? sdy : '0;
    direction = record ? sector : '0;
  end

endmodule

// ===== sv/stroke_direction_sampler_unit.sv =====
// channel | signals                               | role
// in      | in_valid, in_ready, op, x_pos, y_pos  | pointer events
// out     | out_valid, out_ready, accepted ..     | one result per event
// cfg     | cfg_valid, cfg_ready, cfg_index, data | register writes
//
// One event per cycle sustained while out_ready holds. A transferred event
// waits in the input register, then goes through the step logic (two
// squares, add, compare and sector decode) into the result register.
// Stroke state updates at the same edge that loads the result, so the next
// event always sees it. A stalled output holds the result and the input
// register fills, then in_ready drops. Reset clears state and both stages.
module stroke_direction_sampler_unit #(
  parameter int COORD_BITS   = 9,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [COORD_BITS-1:0]               x_pos,
  input  logic [COORD_BITS-1:0]               y_pos,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] segment_index,
  output logic signed [COORD_BITS+3:0]        step_dx,
  output logic signed [COORD_BITS+3:0]        step_dy,
  output logic [sds_pkg::DIR_W-1:0]           direction,
  output logic [COORD_BITS-1:0]               box_min_x,
  output logic [COORD_BITS-1:0]               box_max_x,
  output logic [COORD_BITS-1:0]               box_min_y,
  output logic [COORD_BITS-1:0]               box_max_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [sds_pkg::THR_W-1:0]   min_step_dist_sq;
  logic [sds_pkg::SHIFT_W-1:0] scale_shift;

  logic                  in_full;
  logic                  in_op;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic                  adv;

  logic [COORD_BITS-1:0] anchor_x, anchor_y;
  logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic [CW-1:0]         segment_count;

  sds_pkg::step_ctl_t           ctl;
  logic [COORD_BITS-1:0]        min_x_next, max_x_next, min_y_next, max_y_next;
  logic signed [COORD_BITS+3:0] sdx, sdy;
  logic [sds_pkg::DIR_W-1:0]    dir;

  sds_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .min_step_dist_sq (min_step_dist_sq),
    .scale_shift      (scale_shift)
  );

  sds_step #(.COORD_BITS(COORD_BITS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_step (
    .op               (in_op),
    .x_pos            (in_x),
    .y_pos            (in_y),
    .anchor_x         (anchor_x),
    .anchor_y         (anchor_y),
    .min_x            (min_x),
    .max_x            (max_x),
    .min_y            (min_y),
    .max_y            (max_y),
    .segment_count    (segment_count),
    .min_step_dist_sq (min_step_dist_sq),
    .scale_shift      (scale_shift),
    .ctl              (ctl),
    .min_x_next       (min_x_next),
    .max_x_next       (max_x_next),
    .min_y_next       (min_y_next),
    .max_y_next       (max_y_next),
    .step_dx          (sdx),
    .step_dy          (sdy),
    .direction        (dir)
  );

  // advance the held event when the result register is free or being drained
  assign adv      = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op <= op;
      in_x  <= x_pos;
      in_y  <= y_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x      <= '0;
      anchor_y      <= '0;
      min_x         <= '0;
      max_x         <= '0;
      min_y         <= '0;
      max_y         <= '0;
      segment_count <= '0;
    end else if (adv) begin
      min_x <= min_x_next;
      max_x <= max_x_next;
      min_y <= min_y_next;
      max_y <= max_y_next;
      if (ctl.load_anchor) begin
        anchor_x <= in_x;
        anchor_y <= in_y;
      end
      if (ctl.clear_count) begin
        segment_count <= '0;
      end else if (ctl.bump_count) begin
        segment_count <= segment_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      accepted      <= ctl.bump_count;
      segment_index <= ctl.bump_count ? segment_count[IDX_W-1:0] : '0;
      step_dx       <= sdx;
      step_dy       <= sdy;
      direction     <= dir;
      box_min_x     <= min_x_next;
      box_max_x     <= max_x_next;
      box_min_y     <= min_y_next;
      box_max_y     <= max_y_next;
    end
  end

endmodule

// ===== sv/sds_checker.sv =====
module sds_checker #(
  parameter int COORD_BITS   = 9,
  parameter int MAX_SEGMENTS = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                accepted,
  input logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] segment_index,
  input logic signed [COORD_BITS+3:0]        step_dx,
  input logic signed [COORD_BITS+3:0]        step_dy,
  input logic [sds_pkg::DIR_W-1:0]           direction,
  input logic [COORD_BITS-1:0]               box_min_x,
  input logic [COORD_BITS-1:0]               box_max_x,
  input logic [COORD_BITS-1:0]               box_min_y,
  input logic [COORD_BITS-1:0]               box_max_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_dx) && $stable(direction)
      && $stable(accepted) && $stable(box_max_y))
    else $error("result changed while stalled");

  a_no_segment_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> segment_index == '0 && step_dx == '0 && step_dy == '0
      && direction == '0)
    else $error("segment fields set on a result without a segment");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y)
    else $error("bounding box inverted");

  // lower half-plane sectors carry the top code bit
  a_dir_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> step_dy[COORD_BITS+3] == direction[sds_pkg::DIR_W-1])
    else $error("direction half does not match sign of step_dy");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stroke_direction_sampler_unit sds_checker #(
  .COORD_BITS   (COORD_BITS),
  .MAX_SEGMENTS (MAX_SEGMENTS)
) u_sds_checker (.*);
